FILE: rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LRU block cache: channel payloads,
// sequencer states and search status.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int KEY_BITS          = 64;
   localparam int WORD_BITS         = 64;
   localparam int SLOT_BITS         = 4;
   localparam int CFG_BITS          = 5;
   localparam int DEFAULT_CAPACITY  = 16;
   localparam int DEFAULT_DATA_BITS = 64;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [KEY_BITS-1:0]  node_id;
      logic [KEY_BITS-1:0]  block_id;
      logic [WORD_BITS-1:0] data_word;
   } req_payload_type;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
      logic [WORD_BITS-1:0] read_data;
      logic                 evicted;
   } rsp_payload_type;

   typedef struct packed {
      logic found;
      logic free;
   } scan_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_UPDATE,
      ST_UDRAIN,
      ST_RESP
   } lbc_state_type;

endpackage

FILE: rtl/lbc_ram.sv
// ----------------------------------------------------------------------------
// lbc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lbc_scan.sv
// ----------------------------------------------------------------------------
// lbc_scan
// Search pass tracker: takes one entry per cycle from the tag and rank
// memories and keeps the first key match, the first free entry and the
// least recently used valid entry.
// ----------------------------------------------------------------------------
module lbc_scan #(
   parameter int IDX_W  = 4,
   parameter int DATA_W = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            take,
   input  logic [IDX_W-1:0]                idx,
   input  logic                            entry_valid,
   input  logic [lbc_pkg::KEY_BITS-1:0]    key_node,
   input  logic [lbc_pkg::KEY_BITS-1:0]    key_block,
   input  logic [2*lbc_pkg::KEY_BITS+DATA_W-1:0] rd_tag,
   input  logic [IDX_W-1:0]                rd_rank,
   output lbc_pkg::scan_flags_type         flags,
   output logic [IDX_W-1:0]                found_idx,
   output logic [IDX_W-1:0]                found_rank,
   output logic [DATA_W-1:0]               found_data,
   output logic [IDX_W-1:0]                free_idx,
   output logic [IDX_W-1:0]                vic_idx,
   output logic [IDX_W-1:0]                vic_rank
);

   localparam int TAG_W = 2*lbc_pkg::KEY_BITS + DATA_W;

   logic                    found_ff, found_in;
   logic                    free_ff, free_in;
   logic                    vic_any_ff, vic_any_in;
   logic [IDX_W-1:0]        found_idx_ff, found_rank_ff;
   logic [DATA_W-1:0]       found_data_ff;
   logic [IDX_W-1:0]        free_idx_ff;
   logic [IDX_W-1:0]        vic_idx_ff, vic_rank_ff;
   logic                    match;
   logic                    take_found, take_free, take_vic;

   assign match = entry_valid
                  && (rd_tag[TAG_W-1 -: lbc_pkg::KEY_BITS] == key_node)
                  && (rd_tag[TAG_W-lbc_pkg::KEY_BITS-1 -: lbc_pkg::KEY_BITS] == key_block);

   assign take_found = take && !found_ff && match;
   assign take_free  = take && !free_ff && !entry_valid;
   assign take_vic   = take && entry_valid && (!vic_any_ff || (rd_rank > vic_rank_ff));

   always_comb begin
      found_in   = found_ff;
      free_in    = free_ff;
      vic_any_in = vic_any_ff;
      if (start) begin
         found_in   = 1'b0;
         free_in    = 1'b0;
         vic_any_in = 1'b0;
      end else begin
         if (take_found) found_in = 1'b1;
         if (take_free) free_in = 1'b1;
         if (take_vic) vic_any_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
         vic_any_ff <= 1'b0;
      end else begin
         found_ff   <= found_in;
         free_ff    <= free_in;
         vic_any_ff <= vic_any_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!start && take_found) begin
         found_idx_ff  <= idx;
         found_rank_ff <= rd_rank;
         found_data_ff <= rd_tag[DATA_W-1:0];
      end
      if (!start && take_free) begin
         free_idx_ff <= idx;
      end
      if (!start && take_vic) begin
         vic_idx_ff  <= idx;
         vic_rank_ff <= rd_rank;
      end
   end

   assign flags.found = found_ff;
   assign flags.free  = free_ff;
   assign found_idx   = found_idx_ff;
   assign found_rank  = found_rank_ff;
   assign found_data  = found_data_ff;
   assign free_idx    = free_idx_ff;
   assign vic_idx     = vic_idx_ff;
   assign vic_rank    = vic_rank_ff;

endmodule

FILE: rtl/lbc_block_cache_dummy_guard.sv
// ----------------------------------------------------------------------------
// lbc_rank
// Recency rank update: new rank of one entry when another entry becomes
// the most recent.
// ----------------------------------------------------------------------------
module lbc_rank #(
   parameter int IDX_W    = 4,
   parameter int CAPACITY = 16
) (
   input  logic             entry_valid,
   input  logic             is_target,
   input  logic             fill,
   input  logic [IDX_W-1:0] old_rank,
   input  logic [IDX_W-1:0] cur_rank,
   output logic [IDX_W-1:0] new_rank
);

   localparam logic [IDX_W-1:0] MAX_RANK = IDX_W'(CAPACITY - 1);

   always_comb begin
      new_rank = cur_rank;
      if (is_target) begin
         new_rank = '0;
      end else if (entry_valid && (fill || (cur_rank < old_rank)) && (cur_rank < MAX_RANK)) begin
         new_rank = cur_rank + IDX_W'(1);
      end
   end

endmodule

FILE: rtl/lru_block_cache.sv
// ----------------------------------------------------------------------------
// lru_block_cache
// Fully associative cache keyed by (node_id, block_id) with least recently
// used replacement. Tags and data live in one RAM, recency ranks in another.
//
//   channel | ports                               | direction
//   req     | req_valid, req_ready, req_payload   | in
//   rsp     | rsp_valid, rsp_ready, rsp_payload   | out
//   csr     | csr_valid, csr_ready, csr_wdata     | in
//
// An item takes a search pass, and then a rank pass unless it is a get miss.
// The search pass reads the tag and rank RAMs one entry a cycle over the n
// entries set by csr, and the rank pass reads and writes back the rank RAM one
// entry a cycle. A new request is taken while the previous response waits on rsp.
// Reset and a csr transfer invalidate every entry at once; no clearing pass.
// ----------------------------------------------------------------------------
module lru_block_cache #(
   parameter int CAPACITY  = lbc_pkg::DEFAULT_CAPACITY,
   parameter int DATA_BITS = lbc_pkg::DEFAULT_DATA_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lbc_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lbc_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lbc_pkg::CFG_BITS-1:0]  csr_wdata
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int TAG_W = 2*lbc_pkg::KEY_BITS + DATA_BITS;

   lbc_pkg::lbc_state_type    state_ff, state_in;
   lbc_pkg::req_payload_type  req_ff;
   lbc_pkg::rsp_payload_type  res_ff, res_in;
   lbc_pkg::rsp_payload_type  rsp_ff;
   lbc_pkg::scan_flags_type   flags;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CAPACITY-1:0]       valid_ff, valid_in;
   logic [IDX_W-1:0]          cnt_ff, cnt_in;
   logic                      pend_ff, pend_in;
   logic [IDX_W-1:0]          pend_idx_ff;
   logic [IDX_W-1:0]          tgt_ff, tgt_in;
   logic [IDX_W-1:0]          old_ff, old_in;
   logic                      fill_ff, fill_in;

   logic                      req_fire, csr_fire, cnt_last;
   logic                      ctl_rd, ctl_clr, ctl_inc, ctl_take, ctl_decide;
   logic                      ctl_rank, ctl_load;
   logic                      is_put, upd_need;

   logic [TAG_W-1:0]          tag_rd, tag_wr;
   logic                      tag_we;
   logic [IDX_W-1:0]          rank_rd, rank_wr;
   logic                      rank_we;

   logic [IDX_W-1:0]          found_idx, found_rank, free_idx, vic_idx, vic_rank;
   logic [DATA_BITS-1:0]      found_data;
   logic [IDX_W+3:0]          slot_wide;
   logic [DATA_BITS+63:0]     data_wide;

   assign req_fire = req_valid && req_ready;
   assign csr_fire = csr_valid && csr_ready;
   assign cnt_last = (CNT_W'(cnt_ff) == (n_ff - CNT_W'(1)));
   assign is_put   = (req_ff.req_type == lbc_pkg::REQ_PUT);
   assign upd_need = is_put || flags.found;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbc_pkg::ST_IDLE: begin
            if (req_valid) state_in = lbc_pkg::ST_SCAN;
         end
         lbc_pkg::ST_SCAN: begin
            if (cnt_last) state_in = lbc_pkg::ST_DRAIN;
         end
         lbc_pkg::ST_DRAIN: begin
            state_in = lbc_pkg::ST_DECIDE;
         end
         lbc_pkg::ST_DECIDE: begin
            state_in = upd_need ? lbc_pkg::ST_UPDATE : lbc_pkg::ST_RESP;
         end
         lbc_pkg::ST_UPDATE: begin
            if (cnt_last) state_in = lbc_pkg::ST_UDRAIN;
         end
         lbc_pkg::ST_UDRAIN: begin
            state_in = lbc_pkg::ST_RESP;
         end
         lbc_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = lbc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lbc_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      csr_ready  = 1'b0;
      ctl_rd     = 1'b0;
      ctl_clr    = 1'b0;
      ctl_inc    = 1'b0;
      ctl_take   = 1'b0;
      ctl_decide = 1'b0;
      ctl_rank   = 1'b0;
      ctl_load   = 1'b0;
      unique case (state_ff)
         lbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
            ctl_clr   = 1'b1;
         end
         lbc_pkg::ST_SCAN: begin
            ctl_rd   = 1'b1;
            ctl_inc  = 1'b1;
            ctl_take = 1'b1;
         end
         lbc_pkg::ST_DRAIN: begin
            ctl_take = 1'b1;
         end
         lbc_pkg::ST_DECIDE: begin
            ctl_decide = 1'b1;
            ctl_clr    = 1'b1;
         end
         lbc_pkg::ST_UPDATE: begin
            ctl_rd   = 1'b1;
            ctl_inc  = 1'b1;
            ctl_rank = 1'b1;
         end
         lbc_pkg::ST_UDRAIN: begin
            ctl_rank = 1'b1;
         end
         lbc_pkg::ST_RESP: begin
            ctl_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            ctl_clr = 1'b1;
         end
      endcase
   end

   // counters and pending read
   always_comb begin
      cnt_in = cnt_ff;
      if (ctl_clr) begin
         cnt_in = '0;
      end else if (ctl_inc && !cnt_last) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
      pend_in = ctl_rd;
   end

   // configuration and valid bits
   always_comb begin
      n_in     = n_ff;
      valid_in = valid_ff;
      if (csr_fire) begin
         valid_in = '0;
         if (csr_wdata == '0) begin
            n_in = CNT_W'(1);
         end else if (32'(csr_wdata) > CAPACITY) begin
            n_in = CNT_W'(CAPACITY);
         end else begin
            n_in = CNT_W'(csr_wdata);
         end
      end else if (ctl_decide && is_put && !flags.found) begin
         valid_in[tgt_in] = 1'b1;
      end
   end

   // decision after the search pass
   always_comb begin
      tgt_in  = vic_idx;
      old_in  = vic_rank;
      fill_in = 1'b0;
      if (flags.found) begin
         tgt_in = found_idx;
         old_in = found_rank;
      end else if (flags.free) begin
         tgt_in  = free_idx;
         fill_in = 1'b1;
      end
      slot_wide = {4'b0, tgt_in};
      data_wide = {64'b0, found_data};
      res_in           = '0;
      res_in.hit       = flags.found;
      res_in.slot      = slot_wide[3:0];
      res_in.evicted   = is_put && !flags.found && !flags.free;
      if (!is_put) begin
         if (flags.found) begin
            res_in.read_data = data_wide[63:0];
         end else begin
            res_in.slot = '0;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (ctl_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= CNT_W'(CAPACITY);
         valid_ff     <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= cnt_ff;
      if (req_fire) begin
         req_ff <= req_payload;
      end
      if (ctl_decide) begin
         tgt_ff  <= tgt_in;
         old_ff  <= old_in;
         fill_ff <= fill_in;
         res_ff  <= res_in;
      end
      if (ctl_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign tag_we  = ctl_decide && is_put;
   assign tag_wr  = {req_ff.node_id, req_ff.block_id, req_ff.data_word[DATA_BITS-1:0]};
   assign rank_we = ctl_rank && pend_ff && (valid_ff[pend_idx_ff] || (pend_idx_ff == tgt_ff));

   lbc_ram #(
      .WIDTH (TAG_W),
      .DEPTH (CAPACITY)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tgt_in),
      .wr_data (tag_wr),
      .rd_en   (ctl_rd),
      .rd_addr (cnt_ff),
      .rd_data (tag_rd)
   );

   lbc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CAPACITY)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (pend_idx_ff),
      .wr_data (rank_wr),
      .rd_en   (ctl_rd),
      .rd_addr (cnt_ff),
      .rd_data (rank_rd)
   );

   lbc_scan #(
      .IDX_W  (IDX_W),
      .DATA_W (DATA_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (req_fire),
      .take        (ctl_take && pend_ff),
      .idx         (pend_idx_ff),
      .entry_valid (valid_ff[pend_idx_ff]),
      .key_node    (req_ff.node_id),
      .key_block   (req_ff.block_id),
      .rd_tag      (tag_rd),
      .rd_rank     (rank_rd),
      .flags       (flags),
      .found_idx   (found_idx),
      .found_rank  (found_rank),
      .found_data  (found_data),
      .free_idx    (free_idx),
      .vic_idx     (vic_idx),
      .vic_rank    (vic_rank)
   );

   lbc_rank #(
      .IDX_W    (IDX_W),
      .CAPACITY (CAPACITY)
   ) u_rank (
      .entry_valid (valid_ff[pend_idx_ff]),
      .is_target   (pend_idx_ff == tgt_ff),
      .fill        (fill_ff),
      .old_rank    (old_ff),
      .cur_rank    (rank_rd),
      .new_rank    (rank_wr)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_after_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == lbc_pkg::ST_RESP))
      else $error("response raised outside the response state");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == lbc_pkg::ST_SCAN))
      else $error("accepted request did not start the search pass");

   a_valid_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lbc_pkg::ST_DECIDE && !csr_fire) |=> $stable(valid_ff))
      else $error("valid bits changed outside fill or csr transfer");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.hit && rsp_ff.evicted))
      else $error("response flags both hit and eviction");

   a_rank_write_phase: assert property (@(posedge clock) disable iff (reset)
      rank_we |-> !tag_we && (state_ff != lbc_pkg::ST_SCAN))
      else $error("rank write overlaps the search pass");
`endif

endmodule
